// File: rtl/transformed_box_bounds_defines.svh
// Assertion macros for the RTL of the box bounds block.
`ifndef TRANSFORMED_BOX_BOUNDS_DEFINES_SVH
`define TRANSFORMED_BOX_BOUNDS_DEFINES_SVH
`ifndef SYNTHESIS
`define TBB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbb assertion failed");
`define TBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbb assertion failed");
`else
`define TBB_ASSERT_SAME(lbl, ante, cons)
`define TBB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/tbb_pkg.sv
package tbb_pkg;

    localparam int STORE_DEPTH = 22;
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] IDX_OFFSET_X = 5'd16;
    localparam logic [IDX_W-1:0] IDX_GAIN_X = 5'd17;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Status of the serial divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/tbb_div.sv
module tbb_div #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] num,
    input  logic signed [VALUE_WIDTH-1:0] den,
    output logic signed [VALUE_WIDTH-1:0] quot,
    output tbb_pkg::div_stat_t            stat
);
    import tbb_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, q_reg;
    logic [VW-1:0] den_reg, rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg, busy_reg, done_reg;
    logic [VW-1:0] num_mag, den_mag;
    logic [VW:0]   trial;
    logic          fits;

    assign num_mag = num[VW-1] ? (VW'(0) - num) : num;
    assign den_mag = den[VW-1] ? (VW'(0) - den) : den;
    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits = trial >= {1'b0, den_reg};

    // One quotient bit per cycle, restoring form.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start && !busy_reg) begin
            num_reg <= {num_mag, {FRACTION_BITS{1'b0}}};
            den_reg <= den_mag;
            rem_reg <= '0;
            q_reg <= '0;
            neg_reg <= (num != '0) && (num[VW-1] != den[VW-1]);
        end
        else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            if (fits) begin
                rem_reg <= VW'(trial - {1'b0, den_reg});
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else begin
                rem_reg <= trial[VW-1:0];
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            if (q_reg > (NW'(1) << (VW - 1))) begin
                quot = {1'b1, {(VW-1){1'b0}}};
            end
            else begin
                quot = VW'(NW'(0) - q_reg);
            end
        end
        else begin
            if (q_reg > NW'({1'b0, {(VW-1){1'b1}}})) begin
                quot = {1'b0, {(VW-1){1'b1}}};
            end
            else begin
                quot = q_reg[VW-1:0];
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/transformed_box_bounds.sv
// A load word is written into the coefficient store when it is accepted. A compute word
// takes 8 corners; each is converted, run through the four matrix rows, checked, then
// divided by w (x/w, y/w, z/w) when w is not 0 or 1, and folded into the min/max bounds.
// Throughput: one compute word at a time; busy stays high until the result strobe.
// The receiver cannot stall: min/max appear with done high for one cycle.
// Reset (rst_n, asynchronous) loads the identity matrix, unit gains, zero offsets.
`include "transformed_box_bounds_defines.svh"

module transformed_box_bounds #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [4:0]                    coef_index,
    input  logic signed [VALUE_WIDTH-1:0] coef_value,
    input  logic signed [VALUE_WIDTH-1:0] x_lo,
    input  logic signed [VALUE_WIDTH-1:0] x_hi,
    input  logic signed [VALUE_WIDTH-1:0] y_lo,
    input  logic signed [VALUE_WIDTH-1:0] y_hi,
    input  logic signed [VALUE_WIDTH-1:0] z_lo,
    input  logic signed [VALUE_WIDTH-1:0] z_hi,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] min_x,
    output logic signed [VALUE_WIDTH-1:0] min_y,
    output logic signed [VALUE_WIDTH-1:0] min_z,
    output logic signed [VALUE_WIDTH-1:0] max_x,
    output logic signed [VALUE_WIDTH-1:0] max_y,
    output logic signed [VALUE_WIDTH-1:0] max_z
);
    import tbb_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int AW = 2 * VALUE_WIDTH + 2;
    localparam logic [VW-1:0] MAX_VAL = {1'b0, {(VW-1){1'b1}}};
    localparam logic ONE_FITS = (FRACTION_BITS < VALUE_WIDTH - 1);
    localparam logic [VW-1:0] ONE_VAL = ONE_FITS ? (VW'(1) << FRACTION_BITS) : MAX_VAL;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CONV_MUL = 4'd1;
    localparam logic [3:0] ST_CONV_ADD = 4'd2;
    localparam logic [3:0] ST_ROW_MUL  = 4'd3;
    localparam logic [3:0] ST_ROW_ACC  = 4'd4;
    localparam logic [3:0] ST_ROW_SAT  = 4'd5;
    localparam logic [3:0] ST_CHECK    = 4'd6;
    localparam logic [3:0] ST_DIV_GO   = 4'd7;
    localparam logic [3:0] ST_DIV_WAIT = 4'd8;
    localparam logic [3:0] ST_UPDATE   = 4'd9;

    // Clamp a wide signed value into the output range.
    function automatic logic [VW-1:0] sat_f(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] hi_lim;
        logic signed [AW-1:0] lo_lim;
        hi_lim = $signed({{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}});
        lo_lim = ~hi_lim;
        if (a > hi_lim) begin
            return MAX_VAL;
        end
        else if (a < lo_lim) begin
            return ~MAX_VAL;
        end
        return a[VW-1:0];
    endfunction

    // Round half up and drop the fraction bits of a full product.
    function automatic logic signed [AW-1:0] rnd_f(input logic signed [PW-1:0] p);
        logic signed [AW-1:0] t;
        t = $signed({{(AW-PW){p[PW-1]}}, p}) + $signed(AW'(1) << (FB - 1));
        return t >>> FB;
    endfunction

    logic [3:0] state_reg;
    logic [2:0] corner_reg;
    logic [1:0] axis_reg, col_reg;
    logic       done_reg;

    logic signed [VW-1:0] store_reg [STORE_DEPTH];
    logic signed [VW-1:0] lo_reg [3];
    logic signed [VW-1:0] hi_reg [3];
    logic signed [VW-1:0] u_reg [3];
    logic signed [VW-1:0] r_reg [4];
    logic signed [VW-1:0] mn_reg [3];
    logic signed [VW-1:0] mx_reg [3];
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;

    // The one shared multiplier; its product is registered before use.
    logic signed [VW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] product;
    logic [IDX_W-1:0]     gain_idx, offs_idx, t_idx, t3_idx;
    logic signed [VW-1:0] coord;
    logic                 accept;

    assign accept = start && !busy;
    assign gain_idx = IDX_GAIN_X + {2'b00, axis_reg, 1'b0};
    assign offs_idx = IDX_OFFSET_X + {2'b00, axis_reg, 1'b0};
    assign t_idx = {1'b0, axis_reg, col_reg};
    assign t3_idx = {1'b0, axis_reg, 2'b11};
    assign coord = corner_reg[axis_reg] ? hi_reg[axis_reg] : lo_reg[axis_reg];

    always_comb begin
        if (state_reg == ST_CONV_MUL) begin
            mul_a = coord;
            mul_b = store_reg[gain_idx];
        end
        else begin
            mul_a = store_reg[t_idx];
            mul_b = u_reg[col_reg];
        end
        product = mul_a * mul_b;
    end

    // The serial divider handles x/w, y/w and z/w in turn.
    logic                 div_start;
    logic signed [VW-1:0] div_quot;
    div_stat_t            div_stat;

    assign div_start = (state_reg == ST_DIV_GO);

    tbb_div #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(r_reg[axis_reg]),
        .den(r_reg[3]),
        .quot(div_quot),
        .stat(div_stat)
    );

    // Coefficient store: reset to the identity transform.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
            store_reg[0] <= ONE_VAL;
            store_reg[5] <= ONE_VAL;
            store_reg[10] <= ONE_VAL;
            store_reg[15] <= ONE_VAL;
            store_reg[17] <= ONE_VAL;
            store_reg[19] <= ONE_VAL;
            store_reg[21] <= ONE_VAL;
        end
        else if (accept && cmd == CMD_LOAD && coef_index < IDX_W'(STORE_DEPTH)) begin
            store_reg[coef_index] <= coef_value;
        end
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            corner_reg <= '0;
            axis_reg <= '0;
            col_reg <= '0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept && cmd == CMD_COMPUTE) begin
                        state_reg <= ST_CONV_MUL;
                        corner_reg <= '0;
                        axis_reg <= '0;
                    end
                end
                ST_CONV_MUL: begin
                    state_reg <= ST_CONV_ADD;
                end
                ST_CONV_ADD: begin
                    if (axis_reg == 2'd2) begin
                        axis_reg <= '0;
                        col_reg <= '0;
                        state_reg <= ST_ROW_MUL;
                    end
                    else begin
                        axis_reg <= axis_reg + 1'b1;
                        state_reg <= ST_CONV_MUL;
                    end
                end
                ST_ROW_MUL: begin
                    state_reg <= ST_ROW_ACC;
                end
                ST_ROW_ACC: begin
                    if (col_reg == 2'd2) begin
                        state_reg <= ST_ROW_SAT;
                    end
                    else begin
                        col_reg <= col_reg + 1'b1;
                        state_reg <= ST_ROW_MUL;
                    end
                end
                ST_ROW_SAT: begin
                    col_reg <= '0;
                    if (axis_reg == 2'd3) begin
                        axis_reg <= '0;
                        state_reg <= ST_CHECK;
                    end
                    else begin
                        axis_reg <= axis_reg + 1'b1;
                        state_reg <= ST_ROW_MUL;
                    end
                end
                ST_CHECK: begin
                    if (r_reg[3] != '0 && !(ONE_FITS && r_reg[3] == ONE_VAL)) begin
                        state_reg <= ST_DIV_GO;
                    end
                    else begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        if (axis_reg == 2'd2) begin
                            axis_reg <= '0;
                            state_reg <= ST_UPDATE;
                        end
                        else begin
                            axis_reg <= axis_reg + 1'b1;
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_UPDATE: begin
                    axis_reg <= '0;
                    if (corner_reg == 3'd7) begin
                        state_reg <= ST_IDLE;
                        done_reg <= 1'b1;
                    end
                    else begin
                        corner_reg <= corner_reg + 1'b1;
                        state_reg <= ST_CONV_MUL;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk) begin
        if (accept && cmd == CMD_COMPUTE) begin
            lo_reg[0] <= x_lo;
            hi_reg[0] <= x_hi;
            lo_reg[1] <= y_lo;
            hi_reg[1] <= y_hi;
            lo_reg[2] <= z_lo;
            hi_reg[2] <= z_hi;
        end
        if (state_reg == ST_CONV_MUL || state_reg == ST_ROW_MUL) begin
            prod_reg <= product;
        end
        if (state_reg == ST_CONV_ADD) begin
            u_reg[axis_reg] <= sat_f(rnd_f(prod_reg) + AW'(store_reg[offs_idx]));
            if (axis_reg == 2'd2) begin
                acc_reg <= AW'(store_reg[3]);
            end
        end
        if (state_reg == ST_ROW_ACC) begin
            acc_reg <= acc_reg + rnd_f(prod_reg);
        end
        if (state_reg == ST_ROW_SAT) begin
            r_reg[axis_reg] <= sat_f(acc_reg);
            acc_reg <= AW'(store_reg[IDX_W'(t3_idx + 5'd4)]);
        end
        if (state_reg == ST_DIV_WAIT && div_stat.done) begin
            r_reg[axis_reg] <= div_quot;
        end
        if (state_reg == ST_UPDATE) begin
            for (int i = 0; i < 3; i++) begin
                if (corner_reg == '0 || r_reg[i] < mn_reg[i]) begin
                    mn_reg[i] <= r_reg[i];
                end
                if (corner_reg == '0 || r_reg[i] > mx_reg[i]) begin
                    mx_reg[i] <= r_reg[i];
                end
            end
        end
    end

    // The bounds registers change only in the update step, so they stay
    // stable through the strobe cycle.
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign min_x = mn_reg[0];
    assign min_y = mn_reg[1];
    assign min_z = mn_reg[2];
    assign max_x = mx_reg[0];
    assign max_y = mx_reg[1];
    assign max_z = mx_reg[2];

    `TBB_ASSERT_NEXT(a_strobe_single, done_reg, !done_reg)
    `TBB_ASSERT_SAME(a_strobe_idle, done_reg, !busy)
    `TBB_ASSERT_NEXT(a_compute_busy, accept && cmd == CMD_COMPUTE, busy)
    `TBB_ASSERT_SAME(a_div_only_wait, div_stat.busy, state_reg == ST_DIV_WAIT)

endmodule
